### rtl/lprp_pkg.sv
// shared types and constants of the length-prefixed request parser
package lprp_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned WORD_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS        = CFG_IDX_W'(1);

    localparam logic [WORD_W-1:0] RESET_MAX_MESSAGE_LEN = WORD_W'(32 << 20);
    localparam logic [WORD_W-1:0] RESET_MAX_ARGS        = WORD_W'(200 * 1000);
    localparam logic [WORD_W-1:0] FIELD_BYTES           = WORD_W'(4);

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TOO_LONG  = 3'd1,
        ERR_TOO_MANY  = 3'd2,
        ERR_OVERRUN   = 3'd3,
        ERR_TRAILING  = 3'd4
    } t_err;

    typedef struct packed {
        logic [WORD_W-1:0] max_message_len;
        logic [WORD_W-1:0] max_args;
    } t_limits;

    typedef struct packed {
        logic [7:0]        payload_byte;
        logic              is_payload;
        logic [WORD_W-1:0] arg_index;
        logic              string_end;
        logic              request_end;
        t_err              error_code;
    } t_result;

endpackage

### rtl/lprp_in_if.sv
// input byte channel
interface lprp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       new_connection;

    modport source (output valid, output in_byte, output new_connection, input ready);
    modport sink   (input valid, input in_byte, input new_connection, output ready);
endinterface

### rtl/lprp_out_if.sv
// result channel
interface lprp_out_if;
    import lprp_pkg::*;

    logic              valid;
    logic              ready;
    logic [7:0]        payload_byte;
    logic              is_payload;
    logic [WORD_W-1:0] arg_index;
    logic              string_end;
    logic              request_end;
    logic [2:0]        error_code;

    modport source (output valid, output payload_byte, output is_payload, output arg_index,
                    output string_end, output request_end, output error_code, input ready);
    modport sink   (input valid, input payload_byte, input is_payload, input arg_index,
                    input string_end, input request_end, input error_code, output ready);
endinterface

### rtl/lprp_cfg_if.sv
// configuration write channel
interface lprp_cfg_if;
    import lprp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/lprp_cfg.sv
// configuration registers of the parser limits
module lprp_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lprp_cfg_if.sink          i_cfg,
    output lprp_pkg::t_limits o_limits
);
    import lprp_pkg::*;

    t_limits r_limits;

    assign i_cfg.ready = 1'b1;
    assign o_limits    = r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.max_message_len <= RESET_MAX_MESSAGE_LEN;
            r_limits.max_args        <= RESET_MAX_ARGS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_MESSAGE_LEN: r_limits.max_message_len <= i_cfg.data;
                REG_MAX_ARGS:        r_limits.max_args        <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/lprp_parser.sv
// frame parser state and per-byte result logic
module lprp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_new_connection,
    input  lprp_pkg::t_limits i_limits,
    output lprp_pkg::t_result o_result
);
    import lprp_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_NARGS = 3'd1,
        PH_SLEN  = 3'd2,
        PH_SDATA = 3'd3,
        PH_ERR   = 3'd4
    } t_phase;

    t_phase            r_phase,   n_phase,   s_phase;
    logic [1:0]        r_cnt,     n_cnt,     s_cnt;
    logic [WORD_W-1:0] r_acc,     n_acc,     s_acc;
    logic [WORD_W-1:0] r_body,    n_body,    s_body;
    logic [WORD_W-1:0] r_strs,    n_strs,    s_strs;
    logic [WORD_W-1:0] r_sbytes,  n_sbytes,  s_sbytes;
    logic [WORD_W-1:0] r_arg,     n_arg,     s_arg;
    t_err              r_err,     n_err,     s_err;

    logic [WORD_W-1:0] acc_add;
    logic              field_done;
    logic [WORD_W-1:0] body_dec;
    logic [WORD_W-1:0] sbytes_dec;
    logic [WORD_W-1:0] strs_dec;
    logic              fin;
    t_result           res;

    // state after an optional connection restart
    always_comb begin
        if (i_new_connection) begin
            s_phase  = PH_HDR;
            s_cnt    = '0;
            s_acc    = '0;
            s_body   = '0;
            s_strs   = '0;
            s_sbytes = '0;
            s_arg    = '0;
            s_err    = ERR_NONE;
        end else begin
            s_phase  = r_phase;
            s_cnt    = r_cnt;
            s_acc    = r_acc;
            s_body   = r_body;
            s_strs   = r_strs;
            s_sbytes = r_sbytes;
            s_arg    = r_arg;
            s_err    = r_err;
        end
    end

    assign acc_add    = s_acc | (WORD_W'(i_byte) << {s_cnt, 3'b000});
    assign field_done = (s_cnt == 2'd3);
    assign body_dec   = s_body - WORD_W'(s_body != '0);
    assign sbytes_dec = s_sbytes - WORD_W'(s_sbytes != '0);
    assign strs_dec   = s_strs - WORD_W'(s_strs != '0);

    always_comb begin
        n_phase  = s_phase;
        n_cnt    = s_cnt;
        n_acc    = s_acc;
        n_body   = s_body;
        n_strs   = s_strs;
        n_sbytes = s_sbytes;
        n_arg    = s_arg;
        n_err    = s_err;
        fin      = 1'b0;

        res.payload_byte = i_byte;
        res.is_payload   = 1'b0;
        res.arg_index    = s_arg;
        res.string_end   = 1'b0;
        res.request_end  = 1'b0;
        res.error_code   = ERR_NONE;

        case (s_phase)
            PH_HDR: begin
                n_acc = acc_add;
                n_cnt = s_cnt + 2'd1;
                if (field_done) begin
                    if (acc_add > i_limits.max_message_len) begin
                        n_phase        = PH_ERR;
                        n_err          = ERR_TOO_LONG;
                        res.error_code = ERR_TOO_LONG;
                    end else begin
                        n_body = acc_add;
                        if (acc_add < FIELD_BYTES) begin
                            n_phase        = PH_ERR;
                            n_err          = ERR_OVERRUN;
                            res.error_code = ERR_OVERRUN;
                        end else begin
                            n_phase = PH_NARGS;
                            n_cnt   = '0;
                            n_acc   = '0;
                        end
                    end
                end
            end
            PH_NARGS: begin
                n_body = body_dec;
                n_acc  = acc_add;
                n_cnt  = s_cnt + 2'd1;
                if (field_done) begin
                    if (acc_add > i_limits.max_args) begin
                        n_phase        = PH_ERR;
                        n_err          = ERR_TOO_MANY;
                        res.error_code = ERR_TOO_MANY;
                    end else begin
                        n_strs = acc_add;
                        n_arg  = '0;
                        if (acc_add == '0) begin
                            if (body_dec == '0) begin
                                res.request_end = 1'b1;
                                n_phase         = PH_HDR;
                                n_cnt           = '0;
                                n_acc           = '0;
                            end else begin
                                n_phase        = PH_ERR;
                                n_err          = ERR_TRAILING;
                                res.error_code = ERR_TRAILING;
                            end
                        end else if (body_dec < FIELD_BYTES) begin
                            n_phase        = PH_ERR;
                            n_err          = ERR_OVERRUN;
                            res.error_code = ERR_OVERRUN;
                        end else begin
                            n_phase = PH_SLEN;
                            n_cnt   = '0;
                            n_acc   = '0;
                        end
                    end
                end
            end
            PH_SLEN: begin
                n_body = body_dec;
                n_acc  = acc_add;
                n_cnt  = s_cnt + 2'd1;
                if (field_done) begin
                    if (acc_add > body_dec) begin
                        n_phase        = PH_ERR;
                        n_err          = ERR_OVERRUN;
                        res.error_code = ERR_OVERRUN;
                    end else if (acc_add == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_sbytes = acc_add;
                        n_phase  = PH_SDATA;
                    end
                end
            end
            PH_SDATA: begin
                res.is_payload = 1'b1;
                n_body         = body_dec;
                n_sbytes       = sbytes_dec;
                if (sbytes_dec == '0) begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_phase        = PH_ERR;
                res.error_code = s_err;
            end
        endcase

        // string complete: count it and move to the next field or frame, or to the error phase
        if (fin) begin
            res.string_end = 1'b1;
            n_strs         = strs_dec;
            n_arg          = s_arg + WORD_W'(1);
            if (strs_dec == '0) begin
                if (body_dec == '0) begin
                    res.request_end = 1'b1;
                    n_arg           = '0;
                    n_phase         = PH_HDR;
                    n_cnt           = '0;
                    n_acc           = '0;
                end else begin
                    n_phase        = PH_ERR;
                    n_err          = ERR_TRAILING;
                    res.error_code = ERR_TRAILING;
                end
            end else if (body_dec < FIELD_BYTES) begin
                n_phase        = PH_ERR;
                n_err          = ERR_OVERRUN;
                res.error_code = ERR_OVERRUN;
            end else begin
                n_phase = PH_SLEN;
                n_cnt   = '0;
                n_acc   = '0;
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_body   <= '0;
            r_strs   <= '0;
            r_sbytes <= '0;
            r_arg    <= '0;
            r_err    <= ERR_NONE;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_body   <= n_body;
            r_strs   <= n_strs;
            r_sbytes <= n_sbytes;
            r_arg    <= n_arg;
            r_err    <= n_err;
        end
    end

    a_err_phase_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERR) |-> (r_err != ERR_NONE))
        else $error("error phase without error code");

    a_err_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_new_connection && r_phase == PH_ERR) |=> (r_phase == PH_ERR))
        else $error("error phase left without new connection");

    a_request_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && res.request_end) |-> (res.error_code == ERR_NONE && n_phase == PH_HDR))
        else $error("request end with error or wrong next phase");

endmodule

### rtl/lprp_outbuf.sv
// result register with skid stage
module lprp_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lprp_pkg::t_result i_result,
    output logic              o_push_ready,
    lprp_out_if.source        o_out
);
    import lprp_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    pop;

    assign o_push_ready = !r_skid_valid;
    assign pop          = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.payload_byte = r_out.payload_byte;
    assign o_out.is_payload   = r_out.is_payload;
    assign o_out.arg_index    = r_out.arg_index;
    assign o_out.string_end   = r_out.string_end;
    assign o_out.request_end  = r_out.request_end;
    assign o_out.error_code   = r_out.error_code;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while result register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage did not move to result register");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result changed before transfer");

endmodule

### rtl/length_prefixed_request_parser_top.sv
// Length-prefixed request parser: takes one connection byte per transfer and returns one
// result per byte (payload mark, argument index, string and request end marks, error code).
// A byte can be taken in every cycle while the skid stage is empty. The per-byte state update
// (4-byte field assembly, body and string counters, limit compares) is combinational; its
// result is registered in a two-entry result register with skid stage, which takes one more
// result while the result side stalls. Payload bytes leave before the frame is checked,
// so a request that ends in an error must be dropped downstream. The user must write limits
// through the configuration channel only while the block is idle; this is not enforced.
module length_prefixed_request_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lprp_in_if.sink    i_in,
    lprp_cfg_if.sink   i_cfg,
    lprp_out_if.source o_out
);
    import lprp_pkg::*;

    t_limits limits;
    t_result result;
    logic    push_ready;
    logic    take;

    assign i_in.ready = push_ready;
    assign take       = i_in.valid && push_ready;

    lprp_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_limits (limits)
    );

    lprp_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_byte           (i_in.in_byte),
        .i_new_connection (i_in.new_connection),
        .i_limits         (limits),
        .o_result         (result)
    );

    lprp_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (take),
        .i_result     (result),
        .o_push_ready (push_ready),
        .o_out        (o_out)
    );

endmodule

### dv/tb_top.sv
// self-checking testbench for the length-prefixed request parser
module tb_top;
    import lprp_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 120;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned TAIL_CYCLES     = 16;
    localparam int unsigned TAIL_OPS        = 100;
    localparam int unsigned HOLD_CYCLES     = 200;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned TIMEOUT         = 2000000;

    typedef enum logic [2:0] {
        PS_HDR,
        PS_NARGS,
        PS_SLEN,
        PS_SDATA,
        PS_ERR
    } t_pstate;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_CFG,
        OP_DRAIN,
        OP_HOLD
    } t_op_kind;

    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_LONG,
        FLAW_SHORT,
        FLAW_WILD,
        FLAW_STRLEN
    } t_flaw;

    typedef struct {
        t_op_kind             kind;
        logic [7:0]           data_byte;
        logic                 new_conn;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [WORD_W-1:0]    reg_val;
    } t_stim_op;

    logic clk;
    logic rst_n;

    lprp_in_if  in_ch ();
    lprp_cfg_if cfg_ch ();
    lprp_out_if out_ch ();

    length_prefixed_request_parser_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_stim_op    stim_q[$];
    t_result     expected_results[$];
    int unsigned byte_items   = 0;
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned gap_left     = 0;
    int unsigned settle_cnt   = 0;
    int unsigned span_left    = 0;
    logic        bursts_on    = 1'b0;
    logic        calm_tail    = 1'b0;
    logic        hold_go      = 1'b0;

    // parser state mirror
    t_pstate           pr_phase;
    logic [1:0]        pr_fld_cnt;
    logic [WORD_W-1:0] pr_fld_acc;
    logic [WORD_W-1:0] pr_body_left;
    logic [WORD_W-1:0] pr_strs_left;
    logic [WORD_W-1:0] pr_str_left;
    logic [WORD_W-1:0] pr_arg;
    t_err              pr_err;
    t_limits           pr_lim;
    logic              pr_send;
    logic              pr_rend;
    t_err              pr_code;

    function automatic void clear_parser();
        pr_phase     = PS_HDR;
        pr_fld_cnt   = '0;
        pr_fld_acc   = '0;
        pr_body_left = '0;
        pr_strs_left = '0;
        pr_str_left  = '0;
        pr_arg       = '0;
        pr_err       = ERR_NONE;
    endfunction

    function automatic void start_field(t_pstate ph);
        pr_phase   = ph;
        pr_fld_cnt = '0;
        pr_fld_acc = '0;
    endfunction

    function automatic void raise_error(t_err code);
        pr_err   = code;
        pr_phase = PS_ERR;
        pr_code  = code;
    endfunction

    function automatic bit take_field_byte(logic [7:0] b);
        pr_fld_acc = pr_fld_acc | (WORD_W'(b) << (8 * pr_fld_cnt));
        pr_fld_cnt = pr_fld_cnt + 2'd1;
        return pr_fld_cnt == 2'd0;
    endfunction

    function automatic void use_body_byte();
        if (pr_body_left != 0) pr_body_left = pr_body_left - 1;
    endfunction

    function automatic void close_request();
        if (pr_body_left == 0) begin
            pr_rend = 1'b1;
            pr_arg  = '0;
            start_field(PS_HDR);
        end else begin
            raise_error(ERR_TRAILING);
        end
    endfunction

    function automatic void open_length();
        if (pr_body_left < FIELD_BYTES) raise_error(ERR_OVERRUN);
        else start_field(PS_SLEN);
    endfunction

    function automatic void close_string();
        pr_send = 1'b1;
        if (pr_strs_left != 0) pr_strs_left = pr_strs_left - 1;
        pr_arg = pr_arg + 1;
        if (pr_strs_left == 0) close_request();
        else open_length();
    endfunction

    function automatic t_result parse_byte(logic [7:0] b, logic nc);
        t_result           r;
        logic [WORD_W-1:0] at_arg;
        logic [WORD_W-1:0] v;
        if (nc) clear_parser();
        pr_send = 1'b0;
        pr_rend = 1'b0;
        pr_code = ERR_NONE;
        at_arg  = pr_arg;
        r       = '0;
        case (pr_phase)
            PS_HDR: begin
                if (take_field_byte(b)) begin
                    v = pr_fld_acc;
                    if (v > pr_lim.max_message_len) begin
                        raise_error(ERR_TOO_LONG);
                    end else begin
                        pr_body_left = v;
                        if (v < FIELD_BYTES) raise_error(ERR_OVERRUN);
                        else start_field(PS_NARGS);
                    end
                end
            end
            PS_NARGS: begin
                use_body_byte();
                if (take_field_byte(b)) begin
                    v = pr_fld_acc;
                    if (v > pr_lim.max_args) begin
                        raise_error(ERR_TOO_MANY);
                    end else begin
                        pr_strs_left = v;
                        pr_arg       = '0;
                        if (v == 0) close_request();
                        else open_length();
                    end
                end
            end
            PS_SLEN: begin
                use_body_byte();
                if (take_field_byte(b)) begin
                    v = pr_fld_acc;
                    if (v > pr_body_left) begin
                        raise_error(ERR_OVERRUN);
                    end else if (v == 0) begin
                        close_string();
                    end else begin
                        pr_str_left = v;
                        pr_phase    = PS_SDATA;
                    end
                end
            end
            PS_SDATA: begin
                r.is_payload = 1'b1;
                use_body_byte();
                if (pr_str_left != 0) pr_str_left = pr_str_left - 1;
                if (pr_str_left == 0) close_string();
            end
            default: begin
                pr_phase = PS_ERR;
                pr_code  = pr_err;
            end
        endcase
        r.payload_byte = b;
        r.arg_index    = at_arg;
        r.string_end   = pr_send;
        r.request_end  = pr_rend;
        r.error_code   = pr_code;
        return r;
    endfunction

    function automatic void add_byte(logic [7:0] b, logic nc);
        t_stim_op op;
        op.kind      = OP_BYTE;
        op.data_byte = b;
        op.new_conn  = nc;
        op.reg_idx   = '0;
        op.reg_val   = '0;
        stim_q = {stim_q, op};
        byte_items++;
    endfunction

    function automatic void add_word(logic [WORD_W-1:0] w, logic nc);
        int k;
        for (k = 0; k < 4; k++) add_byte(w[8*k +: 8], (k == 0) ? nc : 1'b0);
    endfunction

    function automatic void add_control(t_op_kind kind, logic [CFG_IDX_W-1:0] idx,
                                        logic [WORD_W-1:0] val);
        t_stim_op op;
        op.kind      = kind;
        op.data_byte = '0;
        op.new_conn  = 1'b0;
        op.reg_idx   = idx;
        op.reg_val   = val;
        stim_q = {stim_q, op};
    endfunction

    function automatic void add_request(t_flaw flaw, logic nc);
        logic [7:0]        body[$];
        logic [WORD_W-1:0] blen;
        logic [WORD_W-1:0] slen;
        int                nargs;
        int                a;
        int                k;
        int                n_pay;
        nargs = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
        for (k = 0; k < 4; k++) body = {body, 8'(nargs >> (8 * k))};
        for (a = 0; a < nargs; a++) begin
            n_pay = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            slen  = n_pay;
            if (flaw == FLAW_STRLEN && a == nargs - 1) slen = slen + $urandom_range(1, 8);
            for (k = 0; k < 4; k++) body = {body, slen[8*k +: 8]};
            for (k = 0; k < n_pay; k++) body = {body, 8'($urandom_range(0, 255))};
        end
        blen = body.size();
        case (flaw)
            FLAW_LONG:  blen = blen + $urandom_range(1, 6);
            FLAW_SHORT: blen = $urandom_range(0, blen - 1);
            FLAW_WILD:  blen = $urandom();
            default: ;
        endcase
        add_word(blen, nc);
        foreach (body[i]) add_byte(body[i], 1'b0);
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch at result %0d: %s expected %0h got %0h",
                         results_seen, name, want, got);
        end
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #(TIMEOUT);
        $display("tb: failure");
        $finish;
    end

    // stretches with and without idling, none near the end
    always @(posedge clk) begin
        if (span_left == 0) begin
            span_left <= $urandom_range(40, 160);
            bursts_on <= $urandom_range(0, 2) != 0;
        end else begin
            span_left <= span_left - 1;
        end
        calm_tail <= stim_q.size() < TAIL_OPS;
    end

    // driver
    always @(posedge clk) begin
        logic                 v_in;
        logic [7:0]           v_byte;
        logic                 v_nc;
        logic                 v_cfg;
        logic [CFG_IDX_W-1:0] v_idx;
        logic [WORD_W-1:0]    v_val;
        logic                 v_hold;
        if (!rst_n) begin
            in_ch.valid  <= 1'b0;
            cfg_ch.valid <= 1'b0;
            hold_go      <= 1'b0;
        end else begin
            v_in   = in_ch.valid;
            v_byte = in_ch.in_byte;
            v_nc   = in_ch.new_connection;
            v_cfg  = cfg_ch.valid;
            v_idx  = cfg_ch.index;
            v_val  = cfg_ch.data;
            v_hold = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                expected_results = {expected_results,
                                    parse_byte(in_ch.in_byte, in_ch.new_connection)};
                void'(stim_q.pop_front());
                v_in = 1'b0;
                if (bursts_on && !calm_tail && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 15);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_MAX_MESSAGE_LEN: pr_lim.max_message_len = cfg_ch.data;
                    REG_MAX_ARGS:        pr_lim.max_args = cfg_ch.data;
                    default: ;
                endcase
                void'(stim_q.pop_front());
                v_cfg = 1'b0;
            end
            if (!v_in && !v_cfg && stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    OP_BYTE: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            v_in   = 1'b1;
                            v_byte = stim_q[0].data_byte;
                            v_nc   = stim_q[0].new_conn;
                        end
                    end
                    OP_CFG: begin
                        v_cfg = 1'b1;
                        v_idx = stim_q[0].reg_idx;
                        v_val = stim_q[0].reg_val;
                    end
                    OP_DRAIN: begin
                        if (expected_results.size() == 0) settle_cnt++;
                        else settle_cnt = 0;
                        if (settle_cnt >= SETTLE_CYCLES) begin
                            settle_cnt = 0;
                            void'(stim_q.pop_front());
                        end
                    end
                    default: begin
                        v_hold = 1'b1;
                        void'(stim_q.pop_front());
                    end
                endcase
            end
            in_ch.valid          <= v_in;
            in_ch.in_byte        <= v_byte;
            in_ch.new_connection <= v_nc;
            cfg_ch.valid         <= v_cfg;
            cfg_ch.index         <= v_idx;
            cfg_ch.data          <= v_val;
            hold_go              <= v_hold;
        end
    end

    // result side stalls
    always @(posedge clk) begin
        int unsigned hold_left;
        int unsigned stall_left;
        logic        rdy;
        if (!rst_n) begin
            hold_left  = 0;
            stall_left = 0;
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_go) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = calm_tail;
            end else begin
                rdy = 1'b1;
                if (bursts_on && !calm_tail && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 15);
            end
            out_ch.ready <= rdy;
        end
    end

    // monitor
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch at result %0d: no byte pending, got byte %0h",
                             results_seen, out_ch.payload_byte);
            end else begin
                want = expected_results.pop_front();
                check_field("payload_byte", WORD_W'(want.payload_byte),
                            WORD_W'(out_ch.payload_byte));
                check_field("is_payload", WORD_W'(want.is_payload),
                            WORD_W'(out_ch.is_payload));
                check_field("arg_index", want.arg_index, out_ch.arg_index);
                check_field("string_end", WORD_W'(want.string_end),
                            WORD_W'(out_ch.string_end));
                check_field("request_end", WORD_W'(want.request_end),
                            WORD_W'(out_ch.request_end));
                check_field("error_code", WORD_W'(want.error_code),
                            WORD_W'(out_ch.error_code));
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic        nc_next;
        int unsigned p;
        int unsigned phase_start;
        int unsigned pick;
        int unsigned n_noise;
        int unsigned k;
        bit          mid_done;
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.in_byte        = '0;
        in_ch.new_connection = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        out_ch.ready         = 1'b0;
        clear_parser();
        pr_lim.max_message_len = RESET_MAX_MESSAGE_LEN;
        pr_lim.max_args        = RESET_MAX_ARGS;

        // empty string, one payload byte, then trailing body with string end
        add_word(32'd14, 1'b1);
        add_word(32'd2, 1'b0);
        add_word(32'd0, 1'b0);
        add_word(32'd1, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        // too many args, then body too short for the count
        add_word(32'd8, 1'b1);
        add_word(32'hFFFF_FFFF, 1'b0);
        add_word(32'd3, 1'b1);

        nc_next = 1'b1;
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                add_control(OP_DRAIN, '0, '0);
                case (p)
                    1: begin
                        add_control(OP_CFG, REG_MAX_MESSAGE_LEN, '1);
                        add_control(OP_CFG, REG_MAX_ARGS, '1);
                    end
                    2: begin
                        add_control(OP_CFG, REG_MAX_MESSAGE_LEN, '0);
                        add_control(OP_CFG, REG_MAX_ARGS, '0);
                    end
                    3: begin
                        add_control(OP_CFG, REG_MAX_ARGS, 32'd2);
                        add_control(OP_CFG, REG_MAX_MESSAGE_LEN, 32'd24);
                    end
                    4: begin
                        add_control(OP_CFG, REG_MAX_MESSAGE_LEN, $urandom_range(8, 64));
                        add_control(OP_CFG, REG_MAX_ARGS, $urandom_range(0, 4));
                        add_control(OP_CFG, CFG_IDX_W'($urandom_range(REG_MAX_ARGS + 1,
                                    {CFG_IDX_W{1'b1}})), $urandom());
                    end
                    default: begin
                        add_control(OP_CFG, REG_MAX_MESSAGE_LEN, 32'd40);
                        add_control(OP_CFG, REG_MAX_ARGS, 32'd3);
                    end
                endcase
            end
            phase_start = byte_items;
            mid_done    = 1'b0;
            while (byte_items - phase_start < ITEMS_PER_PHASE) begin
                if (!mid_done && byte_items - phase_start >= ITEMS_PER_PHASE / 2) begin
                    mid_done = 1'b1;
                    if (p == 1 || p == 4) add_control(OP_HOLD, '0, '0);
                    else if (p == 3) add_control(OP_DRAIN, '0, '0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    add_request(FLAW_NONE, nc_next);
                    nc_next = $urandom_range(0, 4) == 0;
                end else if (pick < 88) begin
                    add_request(t_flaw'($urandom_range(FLAW_LONG, FLAW_STRLEN)), nc_next);
                    nc_next = 1'b1;
                end else begin
                    n_noise = $urandom_range(1, 8);
                    for (k = 0; k < n_noise; k++)
                        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                    nc_next = 1'b1;
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || expected_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lprp_pkg.sv
rtl/lprp_in_if.sv
rtl/lprp_out_if.sv
rtl/lprp_cfg_if.sv
rtl/lprp_cfg.sv
rtl/lprp_parser.sv
rtl/lprp_outbuf.sv
rtl/length_prefixed_request_parser_top.sv
dv/tb_top.sv
